>>> src/abae_pkg.sv
package abae_pkg;

  localparam int CTX_REQ_W = 6;
  localparam int CTX_REQ_N = 1 << CTX_REQ_W;

  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;

  localparam logic [1:0] FUNC_CTX    = 2'd0;
  localparam logic [1:0] FUNC_BYPASS = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  localparam logic CFG_FAST_INERTIA = 1'b0;
  localparam logic CFG_SLOW_INERTIA = 1'b1;

  localparam logic [3:0] FAST_INERTIA_RST = 4'd3;
  localparam logic [3:0] SLOW_INERTIA_RST = 4'd7;

  typedef struct packed {
    logic [1:0]           func;
    logic                 bit_req;
    logic [CTX_REQ_W-1:0] context_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CTX,
    OP_BYPASS,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 bit_req;
    logic [CTX_REQ_W-1:0] ctx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_UPD,
    ST_RENORM,
    ST_FL_SEARCH,
    ST_FL_EMIT
  } state_t;

endpackage

>>> src/abae_ram.sv
module abae_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/abae_front.sv
module abae_front #(
  parameter int CONTEXT_COUNT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  abae_pkg::in_item_t item,
  input  logic               hold,
  output logic               cmd_valid,
  output abae_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);

  logic [abae_pkg::CTX_REQ_W-1:0] ctx_map [abae_pkg::CTX_REQ_N];

  for (genvar i = 0; i < abae_pkg::CTX_REQ_N; i++) begin : g_ctx_map
    assign ctx_map[i] = abae_pkg::CTX_REQ_W'(i % CONTEXT_COUNT);
  end

  abae_pkg::cmd_t                  q [abae_pkg::CMD_DEPTH];
  logic [abae_pkg::CMD_PTR_W-1:0]  wr_ptr;
  logic [abae_pkg::CMD_PTR_W-1:0]  rd_ptr;
  logic [abae_pkg::CMD_PTR_W:0]    count;
  abae_pkg::cmd_t                  cmd_in;
  logic                            known;
  logic                            enq;
  logic                            deq;

  always_comb begin
    cmd_in.bit_req = item.bit_req;
    cmd_in.ctx     = ctx_map[item.context_req];
    cmd_in.op      = abae_pkg::OP_CTX;
    known          = 1'b1;
    case (item.func)
      abae_pkg::FUNC_CTX:    cmd_in.op = abae_pkg::OP_CTX;
      abae_pkg::FUNC_BYPASS: cmd_in.op = abae_pkg::OP_BYPASS;
      abae_pkg::FUNC_FLUSH:  cmd_in.op = abae_pkg::OP_FLUSH;
      default:               known     = 1'b0;
    endcase
  end

  assign full      = hold || (count == (abae_pkg::CMD_PTR_W + 1)'(abae_pkg::CMD_DEPTH));
  // drop the unused code at the door
  assign enq       = push && !full && known;
  assign cmd_valid = (count != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == abae_pkg::CMD_PTR_W'(abae_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == abae_pkg::CMD_PTR_W'(abae_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/abae_out_fifo.sv
module abae_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  abae_pkg::out_item_t wdata,
  output logic                wfull,
  output logic                empty,
  input  logic                pop,
  output abae_pkg::out_item_t result
);

  abae_pkg::out_item_t             mem [abae_pkg::OUT_DEPTH];
  logic [abae_pkg::OUT_PTR_W-1:0]  wr_ptr;
  logic [abae_pkg::OUT_PTR_W-1:0]  rd_ptr;
  logic [abae_pkg::OUT_PTR_W:0]    count;
  logic                            enq;
  logic                            deq;

  assign wfull  = (count == (abae_pkg::OUT_PTR_W + 1)'(abae_pkg::OUT_DEPTH));
  assign empty  = (count == '0);
  assign enq    = wr && !wfull;
  assign deq    = pop && !empty;
  assign result = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == abae_pkg::OUT_PTR_W'(abae_pkg::OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == abae_pkg::OUT_PTR_W'(abae_pkg::OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/abae_core.sv
module abae_core #(
  parameter int CONTEXT_COUNT = 64,
  parameter int PROB_BITS     = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          fast_inertia,
  input  logic [3:0]          slow_inertia,
  input  logic                cmd_valid,
  input  abae_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                clearing,
  output logic                byte_push,
  output abae_pkg::out_item_t byte_data,
  input  logic                fifo_full
);

  localparam int CTX_W  = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
  localparam int HALF_W = PROB_BITS - 1;
  localparam int PROD_W = 32 + PROB_BITS;
  localparam logic [PROB_BITS-1:0] PROB_HALF    = PROB_BITS'(1) << (PROB_BITS - 1);
  localparam logic [HALF_W-1:0]    PROB_QUARTER = HALF_W'(1) << (PROB_BITS - 2);

  function automatic logic [3:0] eff_shift(input logic [3:0] s);
    return (s == 4'd0) ? 4'd1 : s;
  endfunction

  function automatic logic [HALF_W-1:0] adapt_half(input logic [HALF_W-1:0] h,
                                                   input logic b,
                                                   input logic [3:0] s);
    logic [PROB_BITS-1:0] diff;
    diff = PROB_HALF - {1'b0, h};
    if (b) begin
      return h + HALF_W'(diff >> s);
    end
    return h - (h >> s);
  endfunction

  abae_pkg::state_t      state;
  abae_pkg::state_t      state_next;
  abae_pkg::op_t         op_r;
  logic                  bit_r;
  logic [CTX_W-1:0]      ctx_r;
  logic [CTX_W-1:0]      clr_idx;
  logic [31:0]           low_bound;
  logic [31:0]           high_bound;
  logic [31:0]           span;
  logic [PROB_BITS-1:0]  prob;
  logic [PROD_W-1:0]     product;
  logic [1:0]            mask_sel;

  logic                  ram_we;
  logic [CTX_W-1:0]      ram_waddr;
  logic [2*HALF_W-1:0]   ram_wdata;
  logic                  ram_re;
  logic [CTX_W-1:0]      ram_raddr;
  logic [2*HALF_W-1:0]   ram_rdata;

  logic [HALF_W-1:0]     fast_h;
  logic [HALF_W-1:0]     slow_h;
  logic [31:0]           xor_bounds;
  logic                  renorm;
  logic [31:0]           split;
  logic [31:0]           mask;
  logic [31:0]           rnd;
  logic                  hit;

  abae_ram #(
    .WIDTH (2 * HALF_W),
    .DEPTH (CONTEXT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fast_h     = ram_rdata[2*HALF_W-1:HALF_W];
  assign slow_h     = ram_rdata[HALF_W-1:0];
  assign xor_bounds = low_bound ^ high_bound;
  assign renorm     = (xor_bounds[31:24] == 8'h00);
  assign split      = low_bound + product[PROB_BITS +: 32];
  assign mask       = 32'h00ff_ffff >> {mask_sel, 3'b000};
  assign rnd        = (low_bound + mask) & ~mask;
  assign hit        = ((low_bound | mask) != 32'hffff_ffff) && (rnd <= high_bound);

  always_comb begin
    state_next = state;
    case (state)
      abae_pkg::ST_CLEAR: begin
        if (clr_idx == CTX_W'(CONTEXT_COUNT - 1)) begin
          state_next = abae_pkg::ST_IDLE;
        end
      end
      abae_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            abae_pkg::OP_CTX:    state_next = abae_pkg::ST_READ;
            abae_pkg::OP_BYPASS: state_next = abae_pkg::ST_MUL;
            abae_pkg::OP_FLUSH:  state_next = abae_pkg::ST_FL_SEARCH;
            default:             state_next = abae_pkg::ST_IDLE;
          endcase
        end
      end
      abae_pkg::ST_READ:   state_next = abae_pkg::ST_MUL;
      abae_pkg::ST_MUL:    state_next = abae_pkg::ST_UPD;
      abae_pkg::ST_UPD:    state_next = abae_pkg::ST_RENORM;
      abae_pkg::ST_RENORM: begin
        if (!renorm) begin
          state_next = abae_pkg::ST_IDLE;
        end
      end
      abae_pkg::ST_FL_SEARCH: begin
        if (hit || mask_sel == 2'd2) begin
          state_next = abae_pkg::ST_FL_EMIT;
        end
      end
      abae_pkg::ST_FL_EMIT: begin
        if (low_bound == 32'd0) begin
          state_next = abae_pkg::ST_IDLE;
        end
      end
      default: state_next = abae_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    clearing  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ctx_r;
    ram_wdata = {adapt_half(fast_h, bit_r, eff_shift(fast_inertia)),
                 adapt_half(slow_h, bit_r, eff_shift(slow_inertia))};
    ram_re    = 1'b0;
    ram_raddr = CTX_W'(cmd.ctx);
    byte_push = 1'b0;
    byte_data = '{out_byte: low_bound[31:24], last: (xor_bounds[23:16] != 8'h00)};
    case (state)
      abae_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = {PROB_QUARTER, PROB_QUARTER};
      end
      abae_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid;
        ram_re  = cmd_valid;
      end
      abae_pkg::ST_READ: begin
        ram_we = 1'b1;
      end
      abae_pkg::ST_RENORM: begin
        byte_push = renorm && !fifo_full;
      end
      abae_pkg::ST_FL_EMIT: begin
        byte_push = (low_bound != 32'd0) && !fifo_full;
        byte_data = '{out_byte: low_bound[31:24], last: (low_bound[23:0] == 24'd0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= abae_pkg::ST_CLEAR;
      clr_idx    <= '0;
      low_bound  <= 32'd0;
      high_bound <= 32'hffff_ffff;
      mask_sel   <= 2'd0;
    end else begin
      state <= state_next;
      case (state)
        abae_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        abae_pkg::ST_IDLE: begin
          span <= high_bound - low_bound;
          if (cmd_valid) begin
            op_r     <= cmd.op;
            bit_r    <= cmd.bit_req;
            ctx_r    <= CTX_W'(cmd.ctx);
            prob     <= PROB_HALF;
            mask_sel <= 2'd0;
          end
        end
        abae_pkg::ST_READ: begin
          prob <= {1'b0, fast_h} + {1'b0, slow_h};
        end
        abae_pkg::ST_MUL: begin
          product <= PROD_W'(span) * PROD_W'(prob);
        end
        abae_pkg::ST_UPD: begin
          if (bit_r) begin
            high_bound <= split;
          end else begin
            low_bound <= split + 32'd1;
          end
        end
        abae_pkg::ST_RENORM: begin
          // shift out the settled top byte once the output has room
          if (renorm && !fifo_full) begin
            low_bound  <= {low_bound[23:0], 8'h00};
            high_bound <= {high_bound[23:0], 8'hff};
          end
        end
        abae_pkg::ST_FL_SEARCH: begin
          if (hit) begin
            low_bound <= rnd;
          end else begin
            mask_sel <= mask_sel + 2'd1;
          end
        end
        abae_pkg::ST_FL_EMIT: begin
          // low drains to zero, which is also its reset value
          if (low_bound == 32'd0) begin
            high_bound <= 32'hffff_ffff;
          end else if (!fifo_full) begin
            low_bound <= {low_bound[23:0], 8'h00};
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    byte_push |-> !fifo_full)
    else $error("byte pushed into a full output queue");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == abae_pkg::ST_CLEAR) |-> (!cmd_pop && !byte_push))
    else $error("request taken during the table clearing pass");

  a_flush_restores: assert property (@(posedge clk) disable iff (rst)
    (state == abae_pkg::ST_FL_EMIT && low_bound == 32'd0) |=>
      (state == abae_pkg::ST_IDLE && low_bound == 32'd0 && high_bound == 32'hffff_ffff))
    else $error("flush did not restore the bounds");

  a_ctx_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != abae_pkg::ST_CLEAR) |-> (op_r == abae_pkg::OP_CTX))
    else $error("context table written for a request without a context");

endmodule

>>> src/adaptive_binary_arith_encoder.sv
// Context-adaptive binary arithmetic encoder. Requests (context bit, bypass
// bit, flush) go in through a queue-style push/full port; compressed bytes,
// most significant first and marked last on the final byte of each request,
// come out of a four-entry queue read with empty/pop. After reset the block
// clears its context table, one entry per cycle, and holds full high
// meanwhile. A small command queue decouples acceptance from the coding
// core, which handles one request at a time: a context bit steps through
// idle, table read, multiply, bound update and renormalisation; a bypass
// bit skips the table read; a flush searches for a rounding point and then
// emits the bytes of the low bound. The core's bound update is serial:
// table read, one registered multiply, then bound update and byte shifting.
module adaptive_binary_arith_encoder #(
  parameter int CONTEXT_COUNT = 64,
  parameter int PROB_BITS     = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  abae_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output abae_pkg::out_item_t result,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);

  logic [3:0]          fast_inertia;
  logic [3:0]          slow_inertia;
  logic                clearing;
  logic                cmd_valid;
  abae_pkg::cmd_t      cmd;
  logic                cmd_pop;
  logic                byte_push;
  abae_pkg::out_item_t byte_data;
  logic                fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_inertia <= abae_pkg::FAST_INERTIA_RST;
      slow_inertia <= abae_pkg::SLOW_INERTIA_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        abae_pkg::CFG_FAST_INERTIA: fast_inertia <= cfg_data;
        abae_pkg::CFG_SLOW_INERTIA: slow_inertia <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  abae_front #(
    .CONTEXT_COUNT (CONTEXT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .hold      (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  abae_core #(
    .CONTEXT_COUNT (CONTEXT_COUNT),
    .PROB_BITS     (PROB_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fast_inertia (fast_inertia),
    .slow_inertia (slow_inertia),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .clearing     (clearing),
    .byte_push    (byte_push),
    .byte_data    (byte_data),
    .fifo_full    (fifo_full)
  );

  abae_out_fifo u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (byte_push),
    .wdata  (byte_data),
    .wfull  (fifo_full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
